// File: hdl/task_state_table_unit_macros.svh
// Assertion macros shared by the task state table unit.
`ifndef TASK_STATE_TABLE_UNIT_MACROS_SVH
`define TASK_STATE_TABLE_UNIT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define TST_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TST_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hdl/tst_pkg.sv
package tst_pkg;

   typedef enum logic [3:0] {
      OP_CREATE      = 4'd0,
      OP_LOAD        = 4'd1,
      OP_FORK        = 4'd2,
      OP_FREE        = 4'd3,
      OP_EXIT        = 4'd4,
      OP_WAIT        = 4'd5,
      OP_WAKE        = 4'd6,
      OP_BLOCK       = 4'd7,
      OP_UNBLOCK     = 4'd8,
      OP_SLEEP       = 4'd9,
      OP_SLEEP_CHECK = 4'd10,
      OP_QUERY       = 4'd11
   } op_type;

   typedef enum logic [2:0] {
      ST_UNUSED     = 3'd0,
      ST_CREATED    = 3'd1,
      ST_READY      = 3'd2,
      ST_WAIT       = 3'd3,
      ST_BLOCK      = 3'd4,
      ST_SLEEPING   = 3'd5,
      ST_TERMINATED = 3'd6
   } stat_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_FETCH,
      FSM_DISPATCH,
      FSM_FIND,
      FSM_CASCADE,
      FSM_WAKE,
      FSM_UNBLOCK,
      FSM_DONE
   } fsm_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_DISPATCH,
      CMD_FIND,
      CMD_CASCADE,
      CMD_WAKE,
      CMD_UNBLOCK,
      CMD_RESPOND
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } ctrl_cmd_type;

   typedef struct packed {
      logic go_find;
      logic go_cascade;
      logic go_unblock;
      logic found;
      logic scan_last;
      logic changed;
      logic unblk_last;
      logic out_free;
   } dp_status_type;

endpackage

// File: hdl/tst_ctrl.sv
module tst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tst_pkg::dp_status_type dp_st,
   output tst_pkg::ctrl_cmd_type  ctl
);
   import tst_pkg::*;

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl.cmd   = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.cmd  = CMD_CAPTURE;
               state_in = FSM_FETCH;
            end
         end
         FSM_FETCH: begin
            state_in = FSM_DISPATCH;
         end
         FSM_DISPATCH: begin
            ctl.cmd = CMD_DISPATCH;
            if (dp_st.go_find) begin
               state_in = FSM_FIND;
            end else if (dp_st.go_cascade) begin
               state_in = FSM_CASCADE;
            end else if (dp_st.go_unblock) begin
               state_in = FSM_UNBLOCK;
            end else begin
               state_in = FSM_DONE;
            end
         end
         FSM_FIND: begin
            ctl.cmd = CMD_FIND;
            if (dp_st.found || dp_st.scan_last) begin
               state_in = FSM_DONE;
            end
         end
         FSM_CASCADE: begin
            ctl.cmd = CMD_CASCADE;
            if (dp_st.scan_last && !dp_st.changed) begin
               state_in = FSM_WAKE;
            end
         end
         FSM_WAKE: begin
            ctl.cmd = CMD_WAKE;
            if (dp_st.scan_last) begin
               state_in = FSM_DONE;
            end
         end
         FSM_UNBLOCK: begin
            ctl.cmd = CMD_UNBLOCK;
            if (dp_st.unblk_last) begin
               state_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (dp_st.out_free) begin
               ctl.cmd  = CMD_RESPOND;
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/tst_datapath.sv
`include "task_state_table_unit_macros.svh"

module tst_datapath #(
   parameter int NUM_TASKS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tst_pkg::ctrl_cmd_type  ctl,
   output tst_pkg::dp_status_type dp_st,
   input  logic [3:0]            req_op,
   input  logic [4:0]            req_slot,
   input  logic [4:0]            req_target,
   input  logic [31:0]           req_key,
   input  logic [31:0]           req_duration_ms,
   input  logic [31:0]           req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [4:0]            rsp_result_slot,
   output logic                  rsp_ok,
   output logic [2:0]            rsp_status
);
   import tst_pkg::*;

   localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TASKS - 1);

   // Captured command word.
   logic [3:0]  op_ff;
   logic [4:0]  slot_ff, target_ff;
   logic [31:0] key_ff, dur_ff, now_ff;

   // Per-slot state kept in flip-flops; the status, parent and cloned mark are
   // reset, since a slot can come into use without being created.
   stat_type       st_ff     [NUM_TASKS];
   stat_type       st_in     [NUM_TASKS];
   logic [IW-1:0]  parent_ff [NUM_TASKS];
   logic [IW-1:0]  parent_in [NUM_TASKS];
   logic [IW-1:0]  waitt_ff  [NUM_TASKS];
   logic [IW-1:0]  waitt_in  [NUM_TASKS];
   logic [NUM_TASKS-1:0] cloned_ff, cloned_in;
   logic [NUM_TASKS-1:0] term_ff, term_in;

   // Wide per-slot fields held in memories with one shared read port.
   logic [31:0] br_mem    [NUM_TASKS];
   logic [31:0] len_mem   [NUM_TASKS];
   logic [31:0] start_mem [NUM_TASKS];
   logic [31:0] br_rd_ff, len_rd_ff, start_rd_ff;
   logic [IW-1:0] rd_addr;
   logic br_we, sleep_we;

   logic [IW-1:0] scan_ff, scan_in;
   logic          phase_ff, phase_in;
   logic          changed_ff, changed_in;

   logic [4:0]    res_slot_ff, res_slot_in;
   logic [IW-1:0] res_idx_ff, res_idx_in;
   logic          res_in_ff, res_in_in;
   logic          res_ok_ff, res_ok_in;

   logic          rsp_valid_ff;
   logic [4:0]    rsp_slot_ff;
   logic          rsp_ok_ff;
   logic [2:0]    rsp_status_ff;

   logic [IW-1:0] si, ti;
   logic          s_ok, t_ok, s_used, t_used, scan_last;
   logic          casc_hit;
   logic [31:0]   elapsed;
   op_type        op;

   assign op        = op_type'(op_ff);
   assign si        = IW'(slot_ff);
   assign ti        = IW'(target_ff);
   assign s_ok      = 32'(slot_ff) < NUM_TASKS;
   assign t_ok      = 32'(target_ff) < NUM_TASKS;
   assign s_used    = s_ok && (st_ff[si] != ST_UNUSED);
   assign t_used    = t_ok && (st_ff[ti] != ST_UNUSED);
   assign scan_last = (scan_ff == LAST_IDX);
   assign elapsed   = now_ff - start_rd_ff;
   assign casc_hit  = !term_ff[scan_ff] && (st_ff[scan_ff] != ST_UNUSED) &&
                      cloned_ff[scan_ff] && term_ff[parent_ff[scan_ff]];
   assign rd_addr   = (ctl.cmd == CMD_UNBLOCK) ? scan_ff : si;

   assign br_we    = (ctl.cmd == CMD_DISPATCH) && (op == OP_BLOCK) && s_ok &&
                     (st_ff[si] != ST_BLOCK);
   assign sleep_we = (ctl.cmd == CMD_DISPATCH) && (op == OP_SLEEP) && s_ok &&
                     (dur_ff != 32'd0);

   always_comb begin
      dp_st.go_find    = ((op == OP_CREATE) || ((op == OP_FORK) && s_ok));
      dp_st.go_cascade = (op == OP_EXIT) && s_used;
      dp_st.go_unblock = (op == OP_UNBLOCK) && s_ok;
      dp_st.found      = (st_ff[scan_ff] == ST_UNUSED);
      dp_st.scan_last  = scan_last;
      dp_st.changed    = changed_ff || casc_hit;
      dp_st.unblk_last = scan_last && phase_ff;
      dp_st.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      st_in       = st_ff;
      parent_in   = parent_ff;
      waitt_in    = waitt_ff;
      cloned_in   = cloned_ff;
      term_in     = term_ff;
      scan_in     = scan_ff;
      phase_in    = phase_ff;
      changed_in  = changed_ff;
      res_slot_in = res_slot_ff;
      res_idx_in  = res_idx_ff;
      res_in_in   = res_in_ff;
      res_ok_in   = res_ok_ff;

      unique case (ctl.cmd)
         CMD_CAPTURE: begin
            scan_in  = '0;
            phase_in = 1'b0;
         end
         CMD_DISPATCH: begin
            res_slot_in = slot_ff;
            res_idx_in  = si;
            res_in_in   = s_ok;
            res_ok_in   = 1'b0;
            unique case (op)
               OP_CREATE, OP_FORK: begin
                  // Failure values; the search overwrites them on success.
                  res_slot_in = 5'd0;
                  res_idx_in  = '0;
                  res_in_in   = 1'b1;
               end
               OP_LOAD: begin
                  if (s_used) begin
                     st_in[si]     = ST_READY;
                     cloned_in[si] = 1'b0;
                     res_ok_in     = 1'b1;
                  end
               end
               OP_FREE: begin
                  if (s_ok) begin
                     st_in[si] = ST_UNUSED;
                     res_ok_in = 1'b1;
                  end
               end
               OP_EXIT: begin
                  if (s_used) begin
                     term_in     = '0;
                     term_in[si] = 1'b1;
                     st_in[si]   = ST_TERMINATED;
                     changed_in  = 1'b0;
                     res_ok_in   = 1'b1;
                  end
               end
               OP_WAIT: begin
                  res_slot_in = target_ff;
                  res_idx_in  = ti;
                  res_in_in   = t_ok;
                  if (s_ok && t_used) begin
                     waitt_in[si] = ti;
                     st_in[si]    = ST_WAIT;
                     res_ok_in    = 1'b1;
                  end
               end
               OP_WAKE: begin
                  res_slot_in = target_ff;
                  res_idx_in  = ti;
                  res_in_in   = t_ok;
                  if (t_used) begin
                     if ((st_ff[ti] == ST_WAIT) || (st_ff[ti] == ST_BLOCK)) begin
                        st_in[ti] = ST_READY;
                     end
                     res_ok_in = 1'b1;
                  end
               end
               OP_BLOCK: begin
                  if (s_ok) begin
                     st_in[si] = ST_BLOCK;
                     res_ok_in = 1'b1;
                  end
               end
               OP_UNBLOCK: begin
                  res_ok_in = s_ok;
               end
               OP_SLEEP: begin
                  if (s_ok) begin
                     if (dur_ff != 32'd0) begin
                        st_in[si] = ST_SLEEPING;
                     end
                     res_ok_in = 1'b1;
                  end
               end
               OP_SLEEP_CHECK: begin
                  if (s_ok) begin
                     if ((st_ff[si] == ST_SLEEPING) && (len_rd_ff != 32'd0) &&
                         (len_rd_ff <= elapsed)) begin
                        st_in[si] = ST_READY;
                     end
                     res_ok_in = 1'b1;
                  end
               end
               OP_QUERY: begin
                  res_ok_in = s_used;
               end
               default: begin
                  res_ok_in = 1'b0;
               end
            endcase
         end
         CMD_FIND: begin
            if (st_ff[scan_ff] == ST_UNUSED) begin
               cloned_in[scan_ff] = (op == OP_FORK);
               parent_in[scan_ff] = (op == OP_FORK) ? si : '0;
               st_in[scan_ff]     = (op == OP_FORK) ? ST_READY : ST_CREATED;
               res_slot_in        = 5'(scan_ff);
               res_idx_in         = scan_ff;
               res_ok_in          = 1'b1;
            end
            scan_in = scan_ff + IW'(1);
         end
         CMD_CASCADE: begin
            if (casc_hit) begin
               term_in[scan_ff] = 1'b1;
               st_in[scan_ff]   = ST_TERMINATED;
               changed_in       = 1'b1;
            end
            if (scan_last) begin
               scan_in    = '0;
               changed_in = 1'b0;
            end else begin
               scan_in = scan_ff + IW'(1);
            end
         end
         CMD_WAKE: begin
            if ((st_ff[scan_ff] == ST_WAIT) && term_ff[waitt_ff[scan_ff]]) begin
               st_in[scan_ff] = ST_READY;
            end
            scan_in = scan_last ? '0 : scan_ff + IW'(1);
         end
         CMD_UNBLOCK: begin
            // First half of each entry fetches the key, second half compares.
            phase_in = !phase_ff;
            if (phase_ff) begin
               if ((scan_ff != si) && (st_ff[scan_ff] == ST_BLOCK) &&
                   (br_rd_ff == key_ff)) begin
                  st_in[scan_ff] = ST_READY;
               end
               scan_in = scan_last ? '0 : scan_ff + IW'(1);
            end
         end
         default: begin
            scan_in = scan_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            st_ff[i]     <= ST_UNUSED;
            parent_ff[i] <= '0;
         end
         cloned_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
         phase_ff     <= 1'b0;
         changed_ff   <= 1'b0;
      end else begin
         st_ff      <= st_in;
         parent_ff  <= parent_in;
         cloned_ff  <= cloned_in;
         scan_ff    <= scan_in;
         phase_ff   <= phase_in;
         changed_ff <= changed_in;
         if (ctl.cmd == CMD_RESPOND) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      waitt_ff    <= waitt_in;
      term_ff     <= term_in;
      res_slot_ff <= res_slot_in;
      res_idx_ff  <= res_idx_in;
      res_in_ff   <= res_in_in;
      res_ok_ff   <= res_ok_in;
      if (ctl.cmd == CMD_CAPTURE) begin
         op_ff     <= req_op;
         slot_ff   <= req_slot;
         target_ff <= req_target;
         key_ff    <= req_key;
         dur_ff    <= req_duration_ms;
         now_ff    <= req_now_ms;
      end
      if (ctl.cmd == CMD_RESPOND) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_ok_ff     <= res_ok_ff;
         rsp_status_ff <= res_in_ff ? st_ff[res_idx_ff] : ST_UNUSED;
      end
   end

   always_ff @(posedge clock) begin
      if (br_we) begin
         br_mem[si] <= key_ff;
      end
      if (sleep_we) begin
         len_mem[si]   <= dur_ff;
         start_mem[si] <= now_ff;
      end
      br_rd_ff    <= br_mem[rd_addr];
      len_rd_ff   <= len_mem[rd_addr];
      start_rd_ff <= start_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_status      = rsp_status_ff;

   `TST_ASSERT(a_term_grows, (ctl.cmd == CMD_CASCADE) |=> ((term_ff & $past(term_ff)) == $past(term_ff)), "terminated set lost a member during the cascade")
   `TST_ASSERT(a_respond_free, (ctl.cmd == CMD_RESPOND) |-> (!rsp_valid_ff || rsp_ready), "result loaded over an untaken word")
   `TST_ASSERT(a_respond_shows, (ctl.cmd == CMD_RESPOND) |=> rsp_valid_ff, "loaded result not presented")
   `TST_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid_ff, "result valid straight after reset")

endmodule

// File: hdl/task_state_table_unit.sv
// Task state table unit: a fixed table of NUM_TASKS task slots that holds
// each task's status, parent, cloned mark, wait target, block key and sleep
// deadline, and applies one kernel command per request word.
// The request channel (req_valid/req_ready) carries the opcode, the
// addressed slot, a target slot, a block key and the sleep timing fields.
// The response channel (rsp_valid/rsp_ready) returns one word per request:
// the slot involved, a success flag and that slot's status after the command.
// A request is taken only when the unit is idle; it is then captured, the
// per-slot memories are read, and the command is executed. Simple commands
// go from capture through the memory read and dispatch to the response
// register, and the unit then returns to idle for the next request. Create
// and fork walk the slots for the first free one; unblock visits each slot
// in two steps on the shared key memory port, a key fetch and a compare;
// exit walks the table once per cascade pass until a pass terminates no
// further cloned child, plus one waking pass.
// The response sits in an output register, so the unit goes idle and accepts
// the next word while the previous result is still waiting to be taken; it
// only stalls when a new result is ready and the old one has not gone.
// Reset marks every slot unused and drops any pending response at once.
module task_state_table_unit #(
   parameter int NUM_TASKS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_op,
   input  logic [4:0]  req_slot,
   input  logic [4:0]  req_target,
   input  logic [31:0] req_key,
   input  logic [31:0] req_duration_ms,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_result_slot,
   output logic        rsp_ok,
   output logic [2:0]  rsp_status
);
   import tst_pkg::*;

   // Commands from the sequencer and status flags back from the table.
   ctrl_cmd_type  ctl;
   dp_status_type dp_st;

   tst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_st     (dp_st),
      .ctl       (ctl)
   );

   tst_datapath #(
      .NUM_TASKS (NUM_TASKS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .dp_st           (dp_st),
      .req_op          (req_op),
      .req_slot        (req_slot),
      .req_target      (req_target),
      .req_key         (req_key),
      .req_duration_ms (req_duration_ms),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_slot (rsp_result_slot),
      .rsp_ok          (rsp_ok),
      .rsp_status      (rsp_status)
   );

endmodule

// File: sim/task_state_table_unit_test.sv
`timescale 1ns / 100ps

module task_state_table_unit_test;
   import tst_pkg::*;

   localparam int NUM_SLOTS = 32;
   localparam int STALL_LIMIT = 20000;

   // One expected response word, as it should appear on the rsp_ ports.
   typedef struct {
      logic [4:0] result_slot;
      logic       ok;
      logic [2:0] status;
   } answer_type;

   // The scoreboard holds its own copy of the task table. Every accepted
   // request word is applied to that copy at once, and the answer is queued
   // until the matching response word comes back from the unit.
   class task_table_board;
      stat_type    status_of[NUM_SLOTS];
      logic [4:0]  parent_of[NUM_SLOTS];
      logic        cloned[NUM_SLOTS];
      logic        waiting_valid[NUM_SLOTS];
      logic [4:0]  waiting_for[NUM_SLOTS];
      logic [31:0] reason[NUM_SLOTS];
      logic [31:0] nap_length[NUM_SLOTS];
      logic [31:0] nap_start[NUM_SLOTS];
      answer_type  pending[$];
      int          mismatches;

      function void wipe_slot(int i);
         status_of[i] = ST_UNUSED;
         parent_of[i] = 0;
         cloned[i] = 0;
         waiting_valid[i] = 0;
         waiting_for[i] = 0;
         reason[i] = 0;
         nap_length[i] = 0;
         nap_start[i] = 0;
      endfunction

      function void clear_all();
         for (int i = 0; i < NUM_SLOTS; i++) wipe_slot(i);
         pending.delete();
         mismatches = 0;
      endfunction

      function int first_free();
         for (int i = 0; i < NUM_SLOTS; i++)
            if (status_of[i] == ST_UNUSED) return i;
         return -1;
      endfunction

      // Exit: terminate the slot, then keep sweeping for cloned children of
      // anything terminated in this command until a sweep changes nothing.
      // Finally every slot waiting on a terminated slot becomes ready.
      function void terminate_tree(int s);
         bit gone[NUM_SLOTS];
         bit changed;
         for (int i = 0; i < NUM_SLOTS; i++) gone[i] = 0;
         gone[s] = 1;
         status_of[s] = ST_TERMINATED;
         changed = 1;
         while (changed) begin
            changed = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (gone[i] || status_of[i] == ST_UNUSED || !cloned[i]) continue;
               if (gone[parent_of[i]]) begin
                  gone[i] = 1;
                  status_of[i] = ST_TERMINATED;
                  changed = 1;
               end
            end
         end
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (status_of[i] == ST_WAIT && waiting_valid[i] && gone[waiting_for[i]]) begin
               waiting_valid[i] = 0;
               waiting_for[i] = 0;
               status_of[i] = ST_READY;
            end
         end
      endfunction

      function void note_request(logic [3:0] op, logic [4:0] s, logic [4:0] t,
                                 logic [31:0] key, logic [31:0] dur,
                                 logic [31:0] now);
         answer_type a;
         int f;
         a.result_slot = s;
         a.ok = 0;
         case (op)
            OP_CREATE, OP_FORK: begin
               f = first_free();
               if (f < 0) begin
                  a.result_slot = 0;
               end else begin
                  wipe_slot(f);
                  if (op == OP_CREATE) begin
                     status_of[f] = ST_CREATED;
                  end else begin
                     status_of[f] = ST_READY;
                     parent_of[f] = s;
                     cloned[f] = 1;
                  end
                  a.result_slot = f[4:0];
                  a.ok = 1;
               end
            end
            OP_LOAD: begin
               if (status_of[s] != ST_UNUSED) begin
                  status_of[s] = ST_READY;
                  cloned[s] = 0;
                  a.ok = 1;
               end
            end
            OP_FREE: begin
               status_of[s] = ST_UNUSED;
               a.ok = 1;
            end
            OP_EXIT: begin
               if (status_of[s] != ST_UNUSED) begin
                  terminate_tree(s);
                  a.ok = 1;
               end
            end
            OP_WAIT: begin
               a.result_slot = t;
               if (status_of[t] != ST_UNUSED) begin
                  waiting_valid[s] = 1;
                  waiting_for[s] = t;
                  status_of[s] = ST_WAIT;
                  a.ok = 1;
               end
            end
            OP_WAKE: begin
               a.result_slot = t;
               if (status_of[t] != ST_UNUSED) begin
                  if (status_of[t] == ST_WAIT || status_of[t] == ST_BLOCK) begin
                     status_of[t] = ST_READY;
                     reason[t] = 0;
                     waiting_valid[t] = 0;
                     waiting_for[t] = 0;
                  end
                  a.ok = 1;
               end
            end
            OP_BLOCK: begin
               if (status_of[s] != ST_BLOCK) begin
                  status_of[s] = ST_BLOCK;
                  reason[s] = key;
               end
               a.ok = 1;
            end
            OP_UNBLOCK: begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (i != s && status_of[i] == ST_BLOCK && reason[i] == key) begin
                     reason[i] = 0;
                     status_of[i] = ST_READY;
                  end
               end
               a.ok = 1;
            end
            OP_SLEEP: begin
               if (dur != 0) begin
                  status_of[s] = ST_SLEEPING;
                  nap_length[s] = dur;
                  nap_start[s] = now;
               end
               a.ok = 1;
            end
            OP_SLEEP_CHECK: begin
               // Elapsed time wraps modulo 2**32 like the hardware counter.
               if (status_of[s] == ST_SLEEPING && nap_length[s] != 0 &&
                   nap_length[s] <= 32'(now - nap_start[s])) begin
                  status_of[s] = ST_READY;
                  nap_length[s] = 0;
               end
               a.ok = 1;
            end
            OP_QUERY: begin
               a.ok = (status_of[s] != ST_UNUSED);
            end
            default: ;
         endcase
         a.status = status_of[a.result_slot];
         pending.push_back(a);
      endfunction

      function void check_response(logic [4:0] rs, logic ok, logic [2:0] st);
         answer_type a;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response word with nothing expected: slot %0d ok %0d status %0d",
                        rs, ok, st);
            return;
         end
         a = pending.pop_front();
         if (rs !== a.result_slot || ok !== a.ok || st !== a.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected slot %0d ok %0d status %0d, got %0d %0d %0d",
                        a.result_slot, a.ok, a.status, rs, ok, st);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [3:0]  req_op = 0;
   logic [4:0]  req_slot = 0;
   logic [4:0]  req_target = 0;
   logic [31:0] req_key = 0;
   logic [31:0] req_duration_ms = 0;
   logic [31:0] req_now_ms = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [4:0]  rsp_result_slot;
   logic        rsp_ok;
   logic [2:0]  rsp_status;

   task_state_table_unit #(.NUM_TASKS(NUM_SLOTS)) dut (.*);

   always #5 clock = ~clock;

   task_table_board board = new();

   // Idling percentages for the sender and the receiver, and the long hold-off.
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_off = 0;
   int  quiet_cycles = 0;

   // Pool of keys so that block and unblock meet each other often.
   logic [31:0] key_pool[4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001};
   logic [31:0] clock_ms = 0;

   // Checking at the rising edge: the response word and the request word
   // are both taken here, and the scoreboard sees the request first so that
   // a response leaving on the same edge is never confused with it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_request(req_op, req_slot, req_target, req_key,
                               req_duration_ms, req_now_ms);
         if (rsp_valid && rsp_ready)
            board.check_response(rsp_result_slot, rsp_ok, rsp_status);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The receiver stalls at random, or entirely while a hold-off is on.
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 0;
      else
         rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: too long without any word moving ends the run.
   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("task_state_table_unit_test: FAIL");
         $finish;
      end
   end

   // Offer one request word and hold it until the unit takes it. Random
   // gaps come before the word, so valid never drops between two words
   // without a clock edge in between.
   task send_word(logic [3:0] op, logic [4:0] s, logic [4:0] t,
                  logic [31:0] key, logic [31:0] dur, logic [31:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_slot <= s;
      req_target <= t;
      req_key <= key;
      req_duration_ms <= dur;
      req_now_ms <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task lower_valid();
      req_valid <= 0;
      @(posedge clock);
   endtask

   // Random request word. Slots are drawn mostly from the low end, so that
   // tasks created earlier are addressed again, but the whole range is used.
   task send_random();
      logic [3:0] op;
      logic [4:0] s, t;
      logic [31:0] key, dur;
      op = 4'($urandom_range(15));
      if (op > 11 && $urandom_range(3) != 0) op = 4'($urandom_range(11));
      s = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(11));
      t = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(11));
      key = ($urandom_range(3) == 0) ? $urandom : key_pool[$urandom_range(3)];
      case ($urandom_range(3))
         0: dur = 0;
         1: dur = $urandom;
         default: dur = $urandom_range(40);
      endcase
      clock_ms = clock_ms + $urandom_range(20);
      if ($urandom_range(15) == 0) clock_ms = $urandom;
      send_word(op, s, t, key, dur, clock_ms);
   endtask

   // Life of a task family: load a parent and fork from it, then sleep, check,
   // block and unblock by key on a chosen slot, wait on the parent, and finally
   // exit the parent so that the cascade terminates the clone and wakes the waiter.
   task send_lifecycle();
      logic [4:0] p, c;
      logic [31:0] k;
      p = 5'($urandom_range(7));
      c = 5'($urandom_range(11));
      k = key_pool[$urandom_range(3)];
      send_word(OP_CREATE, 0, 0, 0, 0, clock_ms);
      send_word(OP_LOAD, p, 0, 0, 0, clock_ms);
      send_word(OP_FORK, p, 0, 0, 0, clock_ms);
      send_word(OP_SLEEP, c, 0, 0, $urandom_range(30), clock_ms);
      clock_ms = clock_ms + $urandom_range(40);
      send_word(OP_SLEEP_CHECK, c, 0, 0, 0, clock_ms);
      send_word(OP_BLOCK, c, 0, k, 0, clock_ms);
      send_word(OP_UNBLOCK, 5'($urandom_range(11)), 0, k, 0, clock_ms);
      send_word(OP_WAIT, 5'($urandom_range(11)), p, 0, 0, clock_ms);
      send_word(OP_EXIT, p, 0, 0, 0, clock_ms);
      send_word(OP_QUERY, c, 0, 0, 0, clock_ms);
      if ($urandom_range(1)) send_word(OP_FREE, 5'($urandom_range(11)), 0, 0, 0, clock_ms);
   endtask

   task wait_drained();
      lower_valid();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (2 * NUM_SLOTS * 4 + 20) @(posedge clock);
   endtask

   // Long receiver hold-off, counted in its own process.
   task hold_receiver(int cycles);
      hold_off = 1;
      repeat (cycles) @(posedge clock);
      hold_off = 0;
   endtask

   task run_phase(int sender_pct, int receiver_pct, int words);
      int n;
      send_idle_pct = sender_pct;
      recv_stall_pct = receiver_pct;
      n = 0;
      while (n < words) begin
         if ($urandom_range(9) < 6) begin
            send_lifecycle();
            n += 11;
         end else begin
            send_random();
            n++;
         end
      end
   endtask

   initial begin
      board.clear_all();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: every command and the special cases, including an
      // empty table, a full table, a clone chain for exit, a zero-length
      // sleep, a wrapping sleep deadline and unknown opcodes.
      send_word(OP_QUERY, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_LOAD, 5'd0, 0, 0, 0, 0);
      send_word(OP_EXIT, 5'd3, 0, 0, 0, 0);
      send_word(OP_WAIT, 5'd1, 5'd2, 0, 0, 0);
      send_word(OP_WAKE, 5'd0, 5'd2, 0, 0, 0);
      send_word(OP_CREATE, 0, 0, 0, 0, 0);
      send_word(OP_FORK, 5'd0, 0, 0, 0, 0);
      send_word(OP_FORK, 5'd1, 0, 0, 0, 0);
      send_word(OP_WAIT, 5'd5, 5'd2, 0, 0, 0);
      send_word(OP_BLOCK, 5'd6, 0, 32'hDEAD_BEEF, 0, 0);
      send_word(OP_BLOCK, 5'd6, 0, 32'h0, 0, 0);
      send_word(OP_BLOCK, 5'd7, 0, 32'hDEAD_BEEF, 0, 0);
      send_word(OP_UNBLOCK, 5'd7, 0, 32'hDEAD_BEEF, 0, 0);
      send_word(OP_SLEEP, 5'd8, 0, 0, 0, 0);
      send_word(OP_SLEEP, 5'd8, 0, 0, 32'd10, 32'hFFFF_FFFA);
      send_word(OP_SLEEP_CHECK, 5'd8, 0, 0, 0, 32'd2);
      send_word(OP_SLEEP_CHECK, 5'd8, 0, 0, 0, 32'd4);
      send_word(OP_EXIT, 5'd0, 0, 0, 0, 0);
      send_word(OP_WAKE, 5'd0, 5'd7, 0, 0, 0);
      send_word(4'd12, 5'd1, 0, 0, 0, 0);
      send_word(4'd15, 5'd31, 5'd31, 0, 0, 0);
      for (int i = 0; i < NUM_SLOTS + 1; i++) send_word(OP_CREATE, 0, 0, 0, 0, 0);
      send_word(OP_FORK, 5'd31, 0, 0, 0, 0);
      send_word(OP_FREE, 5'd31, 0, 0, 0, 0);
      send_word(OP_FORK, 5'd31, 0, 0, 0, 0);
      wait_drained();
      for (int i = 0; i < NUM_SLOTS; i++) send_word(OP_FREE, 5'(i), 0, 0, 0, 0);

      // Random part over the idling phases; the pressure test sits in the
      // first phase, with the sender still offering words behind it.
      fork
         hold_receiver(600);
         run_phase(0, 0, 150);
      join
      run_phase(50, 0, 135);
      run_phase(0, 50, 135);
      run_phase(13, 13, 135);

      wait_drained();
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("task_state_table_unit_test: PASS");
      end else begin
         $display("task_state_table_unit_test: FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/tst_pkg.sv
hdl/tst_ctrl.sv
hdl/tst_datapath.sv
hdl/task_state_table_unit.sv
sim/task_state_table_unit_test.sv
